// ===== rtl/core/nls_pkg.sv =====
// Package for the nop label search block: widths, defaults, queue entry, result and
// handshake types. No dependencies.
`default_nettype none
package nls_pkg;
    localparam int MemDepthDefault = 256;
    localparam int MaxLabelDefault = 10;
    localparam int AddrW = 8;
    localparam int OpcW = 6;
    localparam int SizeW = 9;
    localparam int LenW = 4;
    localparam int NopsW = 20;
    localparam int CfgAddrW = 2;
    localparam logic [2:0] NopCountReset = 3'd3;
    localparam logic [0:0] OpWrite = 1'b0;
    localparam logic [0:0] OpSearch = 1'b1;
    localparam logic [CfgAddrW-1:0] RegNopCount = 2'd0;

    typedef struct packed {
        logic             operation;
        logic [AddrW-1:0] address;
        logic [OpcW-1:0]  opcode;
        logic [SizeW-1:0] mem_size;
        logic [AddrW-1:0] head_pos;
        logic             backward;
        logic [LenW-1:0]  label_len;
        logic [NopsW-1:0] label_nops;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [AddrW-1:0] new_pos;
    } result_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;
endpackage
`default_nettype wire

// ===== rtl/core/nls_stream_if.sv =====
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing beyond the payload type handed in.
`default_nettype none
interface nls_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nls_front.sv =====
// Front part: accepts items, saturates lengths and sizes, and queues them.
// Depends on nls_pkg.
`default_nettype none
module nls_front #(
    parameter int MEM_DEPTH = nls_pkg::MemDepthDefault,
    parameter int MAX_LABEL = nls_pkg::MaxLabelDefault
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire nls_pkg::item_t in_item,
    output nls_pkg::hs_t       q_hs,
    input  wire logic          q_pop,
    output nls_pkg::item_t     q_item
);
    nls_pkg::item_t q_reg [2];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    nls_pkg::item_t norm;
    logic push;

    always_comb
    begin
        norm = in_item;
        if (32'(in_item.mem_size) > MEM_DEPTH)
            norm.mem_size = nls_pkg::SizeW'(MEM_DEPTH);
        if (32'(in_item.label_len) > MAX_LABEL)
            norm.label_len = nls_pkg::LenW'(MAX_LABEL);
    end

    assign in_ready = cnt_reg != 2'd2;
    assign push = in_valid && in_ready;
    assign q_hs.valid = cnt_reg != 2'd0;
    assign q_hs.ready = in_ready;
    assign q_item = q_reg[rp_reg];

    always_comb
    begin
        wp_next = wp_reg ^ push;
        rp_next = rp_reg ^ (q_pop && q_hs.valid);
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_hs.valid};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= norm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/nls_back.sv =====
// Back part: code memory and the label scan sequencer, one read per cycle.
// Depends on nls_pkg.
`default_nettype none
module nls_back #(
    parameter int MEM_DEPTH = nls_pkg::MemDepthDefault,
    parameter int MAX_LABEL = nls_pkg::MaxLabelDefault
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [2:0]     nop_count,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire nls_pkg::item_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output nls_pkg::result_t    out_res
);
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int PW = AW + 3;
    localparam int LW = $clog2(MAX_LABEL + 1);
    localparam int SW0 = nls_pkg::SizeW > AW + 1 ? nls_pkg::SizeW : AW + 1;
    localparam logic signed [PW-1:0] One = PW'(1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROBE = 7'b0000010,
        S_LO    = 7'b0000100,
        S_HI    = 7'b0001000,
        S_SLIDE = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [nls_pkg::OpcW-1:0] mem [MEM_DEPTH];
    logic [nls_pkg::OpcW-1:0] rd_reg;
    logic [AW-1:0] raddr;
    logic signed [PW-1:0] pos_reg, pos_next, lo_reg, lo_next, hi_reg, hi_next;
    logic signed [PW-1:0] off_reg, off_next, lim_reg, lim_next;
    logic [LW-1:0] m_reg, m_next;
    logic [LW-1:0] len_reg;
    logic [nls_pkg::NopsW-1:0] nops_reg;
    logic [nls_pkg::AddrW-1:0] head_reg;
    logic back_reg;
    logic [SW0-1:0] size_reg;
    logic found_reg, found_next;
    logic [nls_pkg::AddrW-1:0] npos_reg, npos_next;
    logic load;
    logic is_nop;
    logic [1:0] lab_m;
    logic [4:0] sh;
    logic signed [PW-1:0] lenx, headx, sizex, sel_pos;

    assign lenx = PW'(len_reg);
    assign headx = PW'(head_reg);
    assign sizex = PW'(size_reg);
    assign is_nop = {1'b0, rd_reg} < {4'b0, nop_count};
    assign sh = 5'({m_reg, 1'b0});
    assign lab_m = (32'(m_reg) < nls_pkg::NopsW / 2) ? nops_reg[sh +: 2] : 2'd0;
    assign load = state_reg == S_IDLE && q_valid;
    assign q_pop = load;
    assign out_valid = state_reg == S_OUT;
    assign out_res.found = found_reg;
    assign out_res.new_pos = npos_reg;

    always_ff @(posedge clk)
    begin
        if (load && q_item.operation == nls_pkg::OpWrite
            && (AW >= nls_pkg::AddrW || 32'(q_item.address) < MEM_DEPTH))
            mem[AW'(q_item.address)] <= q_item.opcode;
        rd_reg <= mem[raddr];
        if (load)
        begin
            len_reg <= LW'(q_item.label_len);
            nops_reg <= q_item.label_nops;
            head_reg <= q_item.head_pos;
            back_reg <= q_item.backward;
            size_reg <= SW0'(q_item.mem_size);
        end
        pos_reg <= pos_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        off_reg <= off_next;
        lim_reg <= lim_next;
        m_reg <= m_next;
        found_reg <= found_next;
        npos_reg <= npos_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        off_next = off_reg;
        lim_next = lim_reg;
        m_next = m_reg;
        found_next = found_reg;
        npos_next = npos_reg;
        sel_pos = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_item.operation == nls_pkg::OpSearch)
                begin
                    found_next = 1'b0;
                    npos_next = q_item.head_pos;
                    if (q_item.label_len == '0
                        || {1'b0, q_item.head_pos} >= q_item.mem_size)
                        state_next = S_OUT;
                    else
                    begin
                        state_next = S_WAIT;
                        if (q_item.backward)
                        begin
                            lim_next = PW'(q_item.head_pos) - PW'(q_item.label_len);
                            pos_next = lim_next - PW'(q_item.label_len);
                        end
                        else
                        begin
                            lim_next = PW'(q_item.mem_size);
                            pos_next = PW'(q_item.head_pos) + PW'(q_item.label_len);
                        end
                        m_next = '0;
                    end
                end
                sel_pos = pos_next;
            end
            S_WAIT:
            begin
                if ((back_reg && pos_reg < 0) || (!back_reg && pos_reg >= sizex))
                    state_next = S_OUT;
                else
                    state_next = S_PROBE;
                sel_pos = pos_reg;
            end
            S_PROBE:
            begin
                if (is_nop)
                begin
                    lo_next = pos_reg;
                    hi_next = pos_reg + One;
                    state_next = S_LO;
                    sel_pos = pos_reg - One;
                end
                else
                begin
                    pos_next = back_reg ? pos_reg - lenx : pos_reg + lenx;
                    state_next = S_WAIT;
                    sel_pos = pos_next;
                end
            end
            S_LO:
            begin
                if (lo_reg > (back_reg ? PW'(0) : headx) && is_nop)
                begin
                    lo_next = lo_reg - One;
                    sel_pos = lo_reg - One - One;
                    if (lo_reg - One <= (back_reg ? PW'(0) : headx))
                        sel_pos = hi_reg;
                end
                else
                begin
                    state_next = S_HI;
                    sel_pos = hi_reg;
                end
                if (state_next == S_LO && sel_pos == hi_reg)
                    state_next = S_HI;
            end
            S_HI:
            begin
                if (hi_reg < lim_reg && is_nop)
                begin
                    hi_next = hi_reg + One;
                    sel_pos = hi_reg + One;
                end
                else
                begin
                    off_next = lo_reg;
                    m_next = '0;
                    state_next = S_SLIDE;
                    sel_pos = lo_reg;
                end
            end
            default:
            begin
                if (state_reg == S_SLIDE)
                begin
                    if (off_reg + lenx > hi_reg)
                    begin
                        pos_next = back_reg ? lo_reg - One - lenx : hi_reg + lenx;
                        state_next = S_WAIT;
                        sel_pos = pos_next;
                    end
                    else if (m_reg == len_reg)
                    begin
                        found_next = 1'b1;
                        npos_next = nls_pkg::AddrW'(hi_reg - One);
                        state_next = S_OUT;
                    end
                    else if ({4'b0, rd_reg[nls_pkg::OpcW-1:0]} == {8'b0, lab_m})
                    begin
                        m_next = m_reg + 1'b1;
                        sel_pos = off_reg + PW'(m_reg) + One;
                    end
                    else
                    begin
                        off_next = off_reg + One;
                        m_next = '0;
                        sel_pos = off_reg + One;
                    end
                end
                else if (out_ready)
                    state_next = S_IDLE;
            end
        endcase
        raddr = AW'(sel_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== rtl/core/nop_label_search.sv =====
// Nop label search top level: APB register, front queue and scan back end.
// A write is stored in the code memory when it reaches an idle back end; a search
// with an empty label or a head outside memory gives a not-found result without a
// scan, else the back end probes for nops, extends each nop run and compares the
// label. Throughput: one item in the back end at a time, with up to two more held
// in the queue. Reset: rst_n asynchronous active low clears control and sets
// nop_count to 3; the code memory is not cleared.
`default_nettype none
module nop_label_search #(
    parameter int MEM_DEPTH = nls_pkg::MemDepthDefault,
    parameter int MAX_LABEL = nls_pkg::MaxLabelDefault
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    nls_stream_if.sink                   in_ch,
    nls_stream_if.source                 out_ch,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [nls_pkg::CfgAddrW-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    logic [2:0] nop_count_reg;
    nls_pkg::hs_t q_hs;
    logic q_pop;
    nls_pkg::item_t q_item;
    logic in_ready_w;

    assign pready = 1'b1;
    assign prdata = (paddr == nls_pkg::RegNopCount) ? {29'b0, nop_count_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nop_count_reg <= nls_pkg::NopCountReset;
        else if (psel && penable && pwrite && paddr == nls_pkg::RegNopCount)
            nop_count_reg <= pwdata[2:0];
    end

    nls_front #(.MEM_DEPTH(MEM_DEPTH), .MAX_LABEL(MAX_LABEL)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ready_w), .in_item(in_ch.payload),
        .q_hs(q_hs), .q_pop(q_pop), .q_item(q_item)
    );
    assign in_ch.ready = in_ready_w;

    nls_back #(.MEM_DEPTH(MEM_DEPTH), .MAX_LABEL(MAX_LABEL)) u_back (
        .clk(clk), .rst_n(rst_n), .nop_count(nop_count_reg),
        .q_valid(q_hs.valid), .q_pop(q_pop), .q_item(q_item),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.payload)
    );

`ifndef SYNTH
    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_hs.valid) else $error("queue popped while empty");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    a_no_pop_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !q_pop) else $error("pop while result pending");
`endif
endmodule
`default_nettype wire
